FILE: sv/scs_pkg.sv
// shared constants, codes and types for the stick calibrate and scale block
// no dependencies; used by stick_calibrate_and_scale
package scs_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int DEAD_ZONE   = 16;
    localparam int NUM_AXES    = 4;
    localparam int CFG_W       = 10;
    localparam int CFG_UW      = 9;
    localparam int REG_IDX_W   = 3;
    localparam int OUT_DW      = CFG_W + 1;
    // signed working width for samples, center +/- dead zone and spans
    localparam int VW          = SAMPLE_BITS + 2;
    localparam int AW          = VW;
    localparam int OW          = CFG_W;
    localparam int PW          = AW + OW;
    localparam int RW          = PW + 2;
    localparam int CNT_W       = $clog2(PW);

    typedef enum logic [1:0] {
        OP_SEED  = 2'd0,
        OP_WIDEN = 2'd1,
        OP_SCALE = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_THR_MIN = 3'd0,
        REG_THR_MAX = 3'd1,
        REG_PIT_MIN = 3'd2,
        REG_PIT_MAX = 3'd3,
        REG_ROL_MIN = 3'd4,
        REG_ROL_MAX = 3'd5,
        REG_YAW_MIN = 3'd6,
        REG_YAW_MAX = 3'd7
    } t_reg;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SETUP = 6'b000010,
        S_MUL   = 6'b000100,
        S_DIV   = 6'b001000,
        S_FIN   = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    typedef logic        [SAMPLE_BITS-1:0] t_smp;
    typedef logic signed [VW-1:0]          t_val;
    typedef logic signed [VW:0]            t_dif;
    typedef logic signed [CFG_W-1:0]       t_cfg;
    typedef logic        [CFG_UW-1:0]      t_cfgu;
    typedef logic signed [RW-1:0]          t_res;
    typedef logic signed [OUT_DW-1:0]      t_out;

    localparam t_cfg  THR_MIN_RST = 10'sd0;
    localparam t_cfg  THR_MAX_RST = 10'sd255;
    localparam t_cfg  DEF_MIN_RST = -10'sd128;
    localparam t_cfgu DEF_MAX_RST = 9'd127;

endpackage

FILE: sv/stick_calibrate_and_scale.sv
// stick calibration and scaling: min/max/center tracking and per-axis mapping
// depends on scs_pkg (constants, op and register codes, state type)
//
// usage: one input beat carries an op code and four raw stick samples
// (throttle, pitch, roll, yaw); every accepted beat gives exactly one output beat.
// op seed loads min, max and center from the samples, op widen stretches the
// extremes and reports a change, op scale maps all four axes and flags the
// arming pose. configuration is a plain write port (enable, index, data);
// the user must write it only while idle; the block does not enforce this.
// the input channel takes one beat at a time: o_in_stall stays high from the
// accepting edge until the result has been moved into the output register.
// seed, widen and the unused op pass through the states setup and emit; scale
// passes through setup, mul, div, fin and emit. in div the four restoring
// dividers run side by side, one quotient bit per cycle over the 22-bit
// products.
// the output register holds a beat while i_out_stall is high; a finished
// result then waits in the block and no new beat is taken.
// reset (synchronous, active low) clears the extremes and centers to zero,
// loads the default output limits and empties the output register.
module stick_calibrate_and_scale (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_op,
    input  logic [scs_pkg::SAMPLE_BITS-1:0]      i_throttle_in,
    input  logic [scs_pkg::SAMPLE_BITS-1:0]      i_pitch_in,
    input  logic [scs_pkg::SAMPLE_BITS-1:0]      i_roll_in,
    input  logic [scs_pkg::SAMPLE_BITS-1:0]      i_yaw_in,
    // output channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [scs_pkg::CFG_W-1:0]     o_throttle_out,
    output logic signed [scs_pkg::OUT_DW-1:0]    o_pitch_out,
    output logic signed [scs_pkg::CFG_W-1:0]     o_roll_out,
    output logic signed [scs_pkg::OUT_DW-1:0]    o_yaw_out,
    output logic                                 o_armed,
    output logic                                 o_extremes_changed,
    // configuration
    input  logic                                 i_cfg_we,
    input  logic [scs_pkg::REG_IDX_W-1:0]        i_cfg_index,
    input  logic [scs_pkg::CFG_W-1:0]            i_cfg_data
);

    localparam int NA = scs_pkg::NUM_AXES;
    localparam scs_pkg::t_val DZ_V = scs_pkg::t_val'(scs_pkg::DEAD_ZONE);

    scs_pkg::t_state r_state;
    logic            r_out_valid;
    logic [scs_pkg::CNT_W-1:0] r_cnt;

    // configuration
    scs_pkg::t_cfg  r_t_min, r_t_max, r_p_min, r_r_min, r_y_min;
    scs_pkg::t_cfgu r_p_max, r_r_max, r_y_max;

    // calibration state
    scs_pkg::t_smp r_low    [NA];
    scs_pkg::t_smp r_high   [NA];
    scs_pkg::t_smp r_center [NA-1];

    // captured beat
    scs_pkg::t_op  r_op;
    scs_pkg::t_smp r_smp [NA];

    // lane registers
    logic [scs_pkg::AW-1:0] r_na   [NA];
    logic [scs_pkg::OW-1:0] r_nb   [NA];
    logic [scs_pkg::AW-1:0] r_den  [NA];
    logic [scs_pkg::AW-1:0] r_rem  [NA];
    logic [scs_pkg::PW-1:0] r_quo  [NA];
    logic                   r_neg  [NA];
    logic                   r_spz  [NA];
    logic                   r_zero [NA];
    scs_pkg::t_cfg          r_olo  [NA];
    scs_pkg::t_cfg          r_clo  [NA];
    scs_pkg::t_cfg          r_chi  [NA];

    // finished result waiting for the output register
    scs_pkg::t_cfg r_res_thr, r_res_rol;
    scs_pkg::t_out r_res_pit, r_res_yaw;
    logic          r_res_armed, r_res_changed;

    // output register
    scs_pkg::t_cfg r_out_thr, r_out_rol;
    scs_pkg::t_out r_out_pit, r_out_yaw;
    logic          r_out_armed, r_out_changed;

    // per-lane views of center and limits
    scs_pkg::t_smp w_ctr  [NA];
    scs_pkg::t_cfg w_omin [NA];
    scs_pkg::t_cfg w_omax [NA];

    // setup stage
    scs_pkg::t_val          l_x    [NA];
    scs_pkg::t_val          l_ilo  [NA];
    scs_pkg::t_val          l_ihi  [NA];
    scs_pkg::t_cfg          l_olo  [NA];
    scs_pkg::t_cfg          l_ohi  [NA];
    scs_pkg::t_cfg          l_clo  [NA];
    scs_pkg::t_cfg          l_chi  [NA];
    logic                   l_zero [NA];
    logic [scs_pkg::AW-1:0] l_na   [NA];
    logic [scs_pkg::OW-1:0] l_nb   [NA];
    logic [scs_pkg::AW-1:0] l_den  [NA];
    logic                   l_neg  [NA];
    logic                   l_spz  [NA];

    // divider step
    logic [scs_pkg::AW-1:0] n_rem [NA];
    logic                   n_qb  [NA];

    // finish stage
    scs_pkg::t_cfg l_fin [NA];
    scs_pkg::t_out l_pit, l_yaw;
    logic          l_armed;

    // widen
    scs_pkg::t_smp n_low  [NA];
    scs_pkg::t_smp n_high [NA];
    logic          n_changed;

    logic w_in_acc, w_out_acc, w_load_out;

    assign w_ctr[0]  = '0;
    assign w_ctr[1]  = r_center[0];
    assign w_ctr[2]  = r_center[1];
    assign w_ctr[3]  = r_center[2];
    assign w_omin[0] = r_t_min;
    assign w_omin[1] = r_p_min;
    assign w_omin[2] = r_r_min;
    assign w_omin[3] = r_y_min;
    assign w_omax[0] = r_t_max;
    assign w_omax[1] = scs_pkg::t_cfg'({1'b0, r_p_max});
    assign w_omax[2] = scs_pkg::t_cfg'({1'b0, r_r_max});
    assign w_omax[3] = scs_pkg::t_cfg'({1'b0, r_y_max});

    assign o_in_stall  = (r_state != scs_pkg::S_IDLE);
    assign w_in_acc    = i_in_valid && (r_state == scs_pkg::S_IDLE);
    assign w_out_acc   = r_out_valid && !i_out_stall;
    assign w_load_out  = (r_state == scs_pkg::S_EMIT) && (!r_out_valid || !i_out_stall);

    assign o_out_valid        = r_out_valid;
    assign o_throttle_out     = r_out_thr;
    assign o_pitch_out        = r_out_pit;
    assign o_roll_out         = r_out_rol;
    assign o_yaw_out          = r_out_yaw;
    assign o_armed            = r_out_armed;
    assign o_extremes_changed = r_out_changed;

    // lane setup: choose the map's input and output ranges per axis
    always_comb begin
        scs_pkg::t_val cp, cm;
        scs_pkg::t_dif da, db, ds;
        for (int k = 0; k < NA; k++) begin
            cp        = scs_pkg::t_val'(w_ctr[k]) + DZ_V;
            cm        = scs_pkg::t_val'(w_ctr[k]) - DZ_V;
            l_x[k]    = scs_pkg::t_val'(r_smp[k]);
            l_ilo[k]  = scs_pkg::t_val'(r_low[k]);
            l_ihi[k]  = scs_pkg::t_val'(r_high[k]);
            l_olo[k]  = w_omin[k];
            l_ohi[k]  = w_omax[k];
            l_clo[k]  = w_omin[k];
            l_chi[k]  = w_omax[k];
            l_zero[k] = 1'b0;
            if (k != 0) begin
                if (l_x[k] > cp) begin
                    l_ilo[k] = cp;
                    l_olo[k] = '0;
                    l_clo[k] = '0;
                end else if (l_x[k] < cm) begin
                    l_ihi[k] = cm;
                    l_ohi[k] = '0;
                    l_chi[k] = '0;
                end else begin
                    l_zero[k] = 1'b1;
                end
            end
            da = scs_pkg::t_dif'(l_x[k]) - scs_pkg::t_dif'(l_ilo[k]);
            db = scs_pkg::t_dif'(l_ohi[k]) - scs_pkg::t_dif'(l_olo[k]);
            ds = scs_pkg::t_dif'(l_ihi[k]) - scs_pkg::t_dif'(l_ilo[k]);
            l_na[k]  = da[scs_pkg::VW] ? scs_pkg::AW'(-da) : scs_pkg::AW'(da);
            l_nb[k]  = db[scs_pkg::VW] ? scs_pkg::OW'(-db) : scs_pkg::OW'(db);
            l_den[k] = ds[scs_pkg::VW] ? scs_pkg::AW'(-ds) : scs_pkg::AW'(ds);
            l_neg[k] = da[scs_pkg::VW] ^ db[scs_pkg::VW] ^ ds[scs_pkg::VW];
            l_spz[k] = (ds == '0);
        end
    end

    // one restoring divide step per lane
    always_comb begin
        logic [scs_pkg::AW:0] trial;
        for (int k = 0; k < NA; k++) begin
            trial    = {r_rem[k], r_quo[k][scs_pkg::PW-1]};
            n_qb[k]  = (trial >= {1'b0, r_den[k]});
            n_rem[k] = n_qb[k] ? scs_pkg::AW'(trial - {1'b0, r_den[k]})
                               : scs_pkg::AW'(trial);
        end
    end

    // sign, offset and clamp per lane; pitch and yaw inverted; arming pose check
    always_comb begin
        scs_pkg::t_res sq, m, lo, hi, c;
        for (int k = 0; k < NA; k++) begin
            sq = r_neg[k] ? -scs_pkg::t_res'(r_quo[k]) : scs_pkg::t_res'(r_quo[k]);
            m  = r_spz[k] ? scs_pkg::t_res'(r_olo[k]) : sq + scs_pkg::t_res'(r_olo[k]);
            lo = scs_pkg::t_res'(r_clo[k]);
            hi = scs_pkg::t_res'(r_chi[k]);
            if (m < lo) begin
                c = lo;
            end else if (m > hi) begin
                c = hi;
            end else begin
                c = m;
            end
            l_fin[k] = r_zero[k] ? '0 : c[scs_pkg::CFG_W-1:0];
        end
        l_pit   = -scs_pkg::t_out'(l_fin[1]);
        l_yaw   = -scs_pkg::t_out'(l_fin[3]);
        l_armed = (l_fin[0] == r_t_min) && (l_pit == scs_pkg::t_out'(r_p_min))
               && (l_fin[2] == scs_pkg::t_cfg'({1'b0, r_r_max}))
               && (l_yaw == scs_pkg::t_out'(r_y_min));
    end

    // widen extremes toward the sample
    always_comb begin
        n_changed = 1'b0;
        for (int k = 0; k < NA; k++) begin
            n_low[k]  = r_low[k];
            n_high[k] = r_high[k];
            if (r_smp[k] > r_high[k]) begin
                n_high[k] = r_smp[k];
                n_changed = 1'b1;
            end else if (r_smp[k] < r_low[k]) begin
                n_low[k]  = r_smp[k];
                n_changed = 1'b1;
            end
        end
    end

    // control, configuration and calibration state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= scs_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_t_min     <= scs_pkg::THR_MIN_RST;
            r_t_max     <= scs_pkg::THR_MAX_RST;
            r_p_min     <= scs_pkg::DEF_MIN_RST;
            r_p_max     <= scs_pkg::DEF_MAX_RST;
            r_r_min     <= scs_pkg::DEF_MIN_RST;
            r_r_max     <= scs_pkg::DEF_MAX_RST;
            r_y_min     <= scs_pkg::DEF_MIN_RST;
            r_y_max     <= scs_pkg::DEF_MAX_RST;
            for (int k = 0; k < NA; k++) begin
                r_low[k]  <= '0;
                r_high[k] <= '0;
            end
            for (int k = 0; k < NA - 1; k++) begin
                r_center[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (scs_pkg::t_reg'(i_cfg_index))
                    scs_pkg::REG_THR_MIN: r_t_min <= i_cfg_data;
                    scs_pkg::REG_THR_MAX: r_t_max <= i_cfg_data;
                    scs_pkg::REG_PIT_MIN: r_p_min <= i_cfg_data;
                    scs_pkg::REG_PIT_MAX: r_p_max <= i_cfg_data[scs_pkg::CFG_UW-1:0];
                    scs_pkg::REG_ROL_MIN: r_r_min <= i_cfg_data;
                    scs_pkg::REG_ROL_MAX: r_r_max <= i_cfg_data[scs_pkg::CFG_UW-1:0];
                    scs_pkg::REG_YAW_MIN: r_y_min <= i_cfg_data;
                    scs_pkg::REG_YAW_MAX: r_y_max <= i_cfg_data[scs_pkg::CFG_UW-1:0];
                    default: ;
                endcase
            end

            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                scs_pkg::S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= scs_pkg::S_SETUP;
                    end
                end
                scs_pkg::S_SETUP: begin
                    case (r_op)
                        scs_pkg::OP_SEED: begin
                            for (int k = 0; k < NA; k++) begin
                                r_low[k]  <= r_smp[k];
                                r_high[k] <= r_smp[k];
                            end
                            for (int k = 0; k < NA - 1; k++) begin
                                r_center[k] <= r_smp[k+1];
                            end
                            r_state <= scs_pkg::S_EMIT;
                        end
                        scs_pkg::OP_WIDEN: begin
                            for (int k = 0; k < NA; k++) begin
                                r_low[k]  <= n_low[k];
                                r_high[k] <= n_high[k];
                            end
                            r_state <= scs_pkg::S_EMIT;
                        end
                        scs_pkg::OP_SCALE: r_state <= scs_pkg::S_MUL;
                        default:           r_state <= scs_pkg::S_EMIT;
                    endcase
                end
                scs_pkg::S_MUL: begin
                    r_cnt   <= scs_pkg::CNT_W'(scs_pkg::PW - 1);
                    r_state <= scs_pkg::S_DIV;
                end
                scs_pkg::S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= scs_pkg::S_FIN;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                scs_pkg::S_FIN: begin
                    r_state <= scs_pkg::S_EMIT;
                end
                scs_pkg::S_EMIT: begin
                    if (w_load_out) begin
                        r_state <= scs_pkg::S_IDLE;
                    end
                end
                default: r_state <= scs_pkg::S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op     <= scs_pkg::t_op'(i_op);
            r_smp[0] <= i_throttle_in;
            r_smp[1] <= i_pitch_in;
            r_smp[2] <= i_roll_in;
            r_smp[3] <= i_yaw_in;
        end

        case (r_state)
            scs_pkg::S_SETUP: begin
                for (int k = 0; k < NA; k++) begin
                    r_na[k]   <= l_na[k];
                    r_nb[k]   <= l_nb[k];
                    r_den[k]  <= l_den[k];
                    r_neg[k]  <= l_neg[k];
                    r_spz[k]  <= l_spz[k];
                    r_zero[k] <= l_zero[k];
                    r_olo[k]  <= l_olo[k];
                    r_clo[k]  <= l_clo[k];
                    r_chi[k]  <= l_chi[k];
                end
                // results of the ops that finish here
                r_res_thr     <= '0;
                r_res_pit     <= '0;
                r_res_rol     <= '0;
                r_res_yaw     <= '0;
                r_res_armed   <= 1'b0;
                r_res_changed <= (r_op == scs_pkg::OP_WIDEN) ? n_changed : 1'b0;
            end
            scs_pkg::S_MUL: begin
                for (int k = 0; k < NA; k++) begin
                    r_quo[k] <= scs_pkg::PW'(r_na[k]) * scs_pkg::PW'(r_nb[k]);
                    r_rem[k] <= '0;
                end
            end
            scs_pkg::S_DIV: begin
                // dividend shifts out the top while quotient bits enter the bottom
                for (int k = 0; k < NA; k++) begin
                    r_rem[k] <= n_rem[k];
                    r_quo[k] <= {r_quo[k][scs_pkg::PW-2:0], n_qb[k]};
                end
            end
            scs_pkg::S_FIN: begin
                r_res_thr     <= l_fin[0];
                r_res_pit     <= l_pit;
                r_res_rol     <= l_fin[2];
                r_res_yaw     <= l_yaw;
                r_res_armed   <= l_armed;
                r_res_changed <= 1'b0;
            end
            default: ;
        endcase

        if (w_load_out) begin
            r_out_thr     <= r_res_thr;
            r_out_pit     <= r_res_pit;
            r_out_rol     <= r_res_rol;
            r_out_yaw     <= r_res_yaw;
            r_out_armed   <= r_res_armed;
            r_out_changed <= r_res_changed;
        end
    end

endmodule
